/* hw/rtl/bir_pkg.sv */
// bir_pkg: shared types and fixed field widths of the bilinear image resampler
// transaction structs, command, status, config index and ratio divider state codes
// no dependencies
`default_nettype none

package bir_pkg;

    // fixed field widths
    localparam int COORD_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int SRC_DIM_W  = 10;
    localparam int TGT_DIM_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_REQUEST = 1'b1
    } t_cmd;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_RANGE = 1'b1
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_TGT_WIDTH  = 2'd2,
        CFG_TGT_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_LOAD = 2'd1,
        DIV_RUN  = 2'd2
    } t_div_state;

    typedef struct packed {
        t_cmd                       cmd;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pixel_value;
        t_status                    status;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/bilinear_image_resampler.sv */
// bilinear_image_resampler: corner-aligned bilinear resampler over a banked image store
// holds the ratio divider, the load/request pipeline and the two sample banks
// depends on bir_pkg
`default_nettype none

// One transaction per clock, loads and requests mixed freely, whenever busy is low.
// A load writes one sample; a request returns one result on o_strobe through stage
// registers s1 to s5 and the output register. Results arrive in request order and cannot
// be held off. The store is split into even-row and odd-row banks, each read at two
// columns per cycle, so all four neighbours are read in the same cycle. busy is high
// after reset and after every configuration write while a restoring divider forms the
// two scale ratios, one quotient bit per cycle. The store is not cleared: read only
// entries that have been loaded.
module bilinear_image_resampler
    import bir_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RATIO_W   = SRC_DIM_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(RATIO_W);
    localparam int PX_W      = RATIO_W + COORD_W;
    localparam int L_W       = PX_W - FRAC_BITS;
    localparam int BANK_ROWS = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BROW_W    = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int BANK_DEPTH = MAX_SRC_WIDTH * BANK_ROWS;
    localparam int BANK_AW   = $clog2(BANK_DEPTH);
    localparam int DIM_CAP   = (1 << SRC_DIM_W) - 1;
    localparam int SW_CAP    = (MAX_SRC_WIDTH > DIM_CAP) ? DIM_CAP : MAX_SRC_WIDTH;
    localparam int SH_CAP    = (MAX_SRC_HEIGHT > DIM_CAP) ? DIM_CAP : MAX_SRC_HEIGHT;
    localparam int TOP_W     = SAMPLE_W + FRAC_BITS + 2;
    localparam int U_W       = SAMPLE_W + FRAC_BITS + 2;
    localparam int V_W       = 2 * FRAC_BITS + 1;
    localparam int SUM_W     = U_W + 1;
    localparam int Q_W       = SUM_W - FRAC_BITS;

    localparam logic [SRC_DIM_W-1:0] SW_MAX     = SRC_DIM_W'(SW_CAP);
    localparam logic [SRC_DIM_W-1:0] SH_MAX     = SRC_DIM_W'(SH_CAP);
    localparam logic [BANK_AW-1:0]   ROW_STRIDE = BANK_AW'(MAX_SRC_WIDTH);
    localparam logic [FRAC_BITS:0]   ONE_W      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0]     CNT_LAST   = CNT_W'(RATIO_W - 1);

    // ---------------- configuration ----------------
    logic [SRC_DIM_W-1:0] r_src_w, r_src_h;
    logic [TGT_DIM_W-1:0] r_tgt_w, r_tgt_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_DIM_W'(512);
            r_src_h <= SRC_DIM_W'(512);
            r_tgt_w <= TGT_DIM_W'(512);
            r_tgt_h <= TGT_DIM_W'(512);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_TGT_WIDTH:  r_tgt_w <= i_cfg_data[TGT_DIM_W-1:0];
                CFG_TGT_HEIGHT: r_tgt_h <= i_cfg_data[TGT_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, source capped at the store size
    logic [SRC_DIM_W-1:0] sw, sh, sw_m1, sh_m1;
    logic [TGT_DIM_W-1:0] tw, th, tw_m1, th_m1;

    always_comb begin
        sw = (r_src_w == '0) ? SRC_DIM_W'(1) : ((r_src_w > SW_MAX) ? SW_MAX : r_src_w);
        sh = (r_src_h == '0) ? SRC_DIM_W'(1) : ((r_src_h > SH_MAX) ? SH_MAX : r_src_h);
        tw = (r_tgt_w == '0) ? TGT_DIM_W'(1) : r_tgt_w;
        th = (r_tgt_h == '0) ? TGT_DIM_W'(1) : r_tgt_h;
        sw_m1 = sw - SRC_DIM_W'(1);
        sh_m1 = sh - SRC_DIM_W'(1);
        tw_m1 = tw - TGT_DIM_W'(1);
        th_m1 = th - TGT_DIM_W'(1);
    end

    // ---------------- ratio divider ----------------
    t_div_state       r_div_state, n_div_state;
    logic             div_init, div_step, div_busy;
    logic [CNT_W-1:0] r_div_cnt;

    always_comb begin
        n_div_state = r_div_state;
        case (r_div_state)
            DIV_IDLE: n_div_state = DIV_IDLE;
            DIV_LOAD: n_div_state = DIV_RUN;
            DIV_RUN:  n_div_state = (r_div_cnt == '0) ? DIV_IDLE : DIV_RUN;
            default:  n_div_state = DIV_IDLE;
        endcase
        if (i_cfg_we) begin
            n_div_state = DIV_LOAD;
        end
    end

    always_comb begin
        div_init = 1'b0;
        div_step = 1'b0;
        div_busy = 1'b1;
        case (r_div_state)
            DIV_IDLE: div_busy = 1'b0;
            DIV_LOAD: div_init = 1'b1;
            DIV_RUN:  div_step = 1'b1;
            default:  div_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_state <= DIV_LOAD;
        end else begin
            r_div_state <= n_div_state;
        end
    end

    logic [RATIO_W-1:0]   r_cq, r_rq, r_col_ratio, r_row_ratio;
    logic [TGT_DIM_W-1:0] r_crem, r_rrem;
    logic [TGT_DIM_W+1:0] c_trial, r_trial;
    logic                 c_ge, r_ge;
    logic [TGT_DIM_W-1:0] c_rem_nx, r_rem_nx;
    logic [RATIO_W-1:0]   c_q_nx, r_q_nx;

    always_comb begin
        c_trial  = {1'b0, r_crem, r_cq[RATIO_W-1]} - {2'b00, tw_m1};
        c_ge     = !c_trial[TGT_DIM_W+1];
        c_rem_nx = c_ge ? c_trial[TGT_DIM_W-1:0] : {r_crem[TGT_DIM_W-2:0], r_cq[RATIO_W-1]};
        c_q_nx   = {r_cq[RATIO_W-2:0], c_ge};
        r_trial  = {1'b0, r_rrem, r_rq[RATIO_W-1]} - {2'b00, th_m1};
        r_ge     = !r_trial[TGT_DIM_W+1];
        r_rem_nx = r_ge ? r_trial[TGT_DIM_W-1:0] : {r_rrem[TGT_DIM_W-2:0], r_rq[RATIO_W-1]};
        r_q_nx   = {r_rq[RATIO_W-2:0], r_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_ratio <= '0;
            r_row_ratio <= '0;
            r_div_cnt   <= '0;
        end else if (div_init) begin
            r_div_cnt <= CNT_LAST;
        end else if (div_step) begin
            r_div_cnt <= r_div_cnt - CNT_W'(1);
            if (r_div_cnt == '0) begin
                // a target size of one maps everything onto the first sample
                r_col_ratio <= (tw_m1 == '0) ? '0 : c_q_nx;
                r_row_ratio <= (th_m1 == '0) ? '0 : r_q_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_init) begin
            r_cq   <= {sw_m1, {FRAC_BITS{1'b0}}};
            r_rq   <= {sh_m1, {FRAC_BITS{1'b0}}};
            r_crem <= '0;
            r_rrem <= '0;
        end else if (div_step) begin
            r_cq   <= c_q_nx;
            r_rq   <= r_q_nx;
            r_crem <= c_rem_nx;
            r_rrem <= r_rem_nx;
        end
    end

    assign busy = div_busy;

    // ---------------- stage 1: accept, range checks, coordinate scaling ----------------
    logic accept;
    assign accept = start && !busy;

    logic                       r_s1_vld;
    logic                       r_s1_load, r_s1_keep, r_s1_oob;
    logic [COORD_W-1:0]         r_s1_col, r_s1_row;
    logic [SAMPLE_W-1:0]        r_s1_sample;
    logic [PX_W-1:0]            r_s1_px, r_s1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_load   <= (i_item.cmd == CMD_LOAD);
        r_s1_keep   <= (i_item.col < COORD_W'(sw)) && (i_item.row < COORD_W'(sh));
        r_s1_oob    <= (TGT_DIM_W'(i_item.col) >= tw) || (TGT_DIM_W'(i_item.row) >= th);
        r_s1_col    <= i_item.col;
        r_s1_row    <= i_item.row;
        r_s1_sample <= i_item.sample;
        r_s1_px     <= PX_W'(r_col_ratio) * PX_W'(i_item.col);
        r_s1_py     <= PX_W'(r_row_ratio) * PX_W'(i_item.row);
    end

    // ---------------- stage 2: neighbours, weights, bank addresses ----------------
    logic [L_W-1:0]       lx, ly;
    logic                 clamp_x, clamp_y;
    logic [SRC_DIM_W-1:0] xl, xh, yl, yh, y_even, y_odd;
    logic [FRAC_BITS-1:0] wx, wy;
    logic [BANK_AW-1:0]   base_even, base_odd, load_addr;

    always_comb begin
        lx      = r_s1_px[PX_W-1:FRAC_BITS];
        ly      = r_s1_py[PX_W-1:FRAC_BITS];
        clamp_x = lx >= L_W'(sw_m1);
        clamp_y = ly >= L_W'(sh_m1);
        xl      = clamp_x ? sw_m1 : lx[SRC_DIM_W-1:0];
        xh      = clamp_x ? sw_m1 : xl + SRC_DIM_W'(1);
        yl      = clamp_y ? sh_m1 : ly[SRC_DIM_W-1:0];
        yh      = clamp_y ? sh_m1 : yl + SRC_DIM_W'(1);
        wx      = clamp_x ? '0 : r_s1_px[FRAC_BITS-1:0];
        wy      = clamp_y ? '0 : r_s1_py[FRAC_BITS-1:0];
        // the two rows always fall in different banks unless clamped
        y_even  = yl[0] ? yh : yl;
        y_odd   = yl[0] ? yl : yh;
        base_even = BANK_AW'(BROW_W'(y_even[SRC_DIM_W-1:1])) * ROW_STRIDE;
        base_odd  = BANK_AW'(BROW_W'(y_odd[SRC_DIM_W-1:1])) * ROW_STRIDE;
        load_addr = BANK_AW'(BROW_W'(r_s1_row[COORD_W-1:1])) * ROW_STRIDE
                  + BANK_AW'(r_s1_col);
    end

    logic                 r_s2_rsp, r_s2_req, r_s2_oob;
    logic                 r_s2_we_even, r_s2_we_odd;
    logic [BANK_AW-1:0]   r_s2_waddr;
    logic [SAMPLE_W-1:0]  r_s2_wdata;
    logic [BANK_AW-1:0]   r_s2_even_lo, r_s2_even_hi, r_s2_odd_lo, r_s2_odd_hi;
    logic                 r_s2_top_odd, r_s2_row_same, r_s2_col_same;
    logic [FRAC_BITS-1:0] r_s2_wx, r_s2_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_rsp     <= 1'b0;
            r_s2_req     <= 1'b0;
            r_s2_we_even <= 1'b0;
            r_s2_we_odd  <= 1'b0;
        end else begin
            r_s2_rsp     <= r_s1_vld && !r_s1_load;
            r_s2_req     <= r_s1_vld && !r_s1_load && !r_s1_oob;
            r_s2_we_even <= r_s1_vld && r_s1_load && r_s1_keep && !r_s1_row[0];
            r_s2_we_odd  <= r_s1_vld && r_s1_load && r_s1_keep && r_s1_row[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_oob      <= r_s1_oob;
        r_s2_waddr    <= load_addr;
        r_s2_wdata    <= r_s1_sample;
        r_s2_even_lo  <= base_even + BANK_AW'(xl);
        r_s2_even_hi  <= base_even + BANK_AW'(xh);
        r_s2_odd_lo   <= base_odd + BANK_AW'(xl);
        r_s2_odd_hi   <= base_odd + BANK_AW'(xh);
        r_s2_top_odd  <= yl[0];
        r_s2_row_same <= clamp_y;
        r_s2_col_same <= clamp_x;
        r_s2_wx       <= wx;
        r_s2_wy       <= wy;
    end

    // ---------------- stage 3: image banks ----------------
    // loads and requests reach this stage in accept order, so no forwarding is needed
    logic [SAMPLE_W-1:0] r_mem_even [BANK_DEPTH];
    logic [SAMPLE_W-1:0] r_mem_odd  [BANK_DEPTH];
    logic [SAMPLE_W-1:0] r_s3_even_lo, r_s3_even_hi, r_s3_odd_lo, r_s3_odd_hi;

    always_ff @(posedge i_clk) begin
        if (r_s2_we_even) begin
            r_mem_even[r_s2_waddr] <= r_s2_wdata;
        end
        if (r_s2_req) begin
            r_s3_even_lo <= r_mem_even[r_s2_even_lo];
            r_s3_even_hi <= r_mem_even[r_s2_even_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_we_odd) begin
            r_mem_odd[r_s2_waddr] <= r_s2_wdata;
        end
        if (r_s2_req) begin
            r_s3_odd_lo <= r_mem_odd[r_s2_odd_lo];
            r_s3_odd_hi <= r_mem_odd[r_s2_odd_hi];
        end
    end

    logic                 r_s3_vld, r_s3_oob;
    logic                 r_s3_top_odd, r_s3_row_same, r_s3_col_same;
    logic [FRAC_BITS-1:0] r_s3_wx, r_s3_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_oob      <= r_s2_oob;
        r_s3_top_odd  <= r_s2_top_odd;
        r_s3_row_same <= r_s2_row_same;
        r_s3_col_same <= r_s2_col_same;
        r_s3_wx       <= r_s2_wx;
        r_s3_wy       <= r_s2_wy;
    end

    // ---------------- stage 4: horizontal blend ----------------
    logic signed [SAMPLE_W-1:0] sa, sb, sc, sd;
    logic [SAMPLE_W-1:0]        bot_lo, bot_hi;
    logic [FRAC_BITS:0]         omx;
    logic signed [TOP_W-1:0]    top_sum, bot_sum;

    always_comb begin
        sa     = r_s3_top_odd ? r_s3_odd_lo : r_s3_even_lo;
        sb     = r_s3_col_same ? sa : (r_s3_top_odd ? r_s3_odd_hi : r_s3_even_hi);
        bot_lo = r_s3_top_odd ? r_s3_even_lo : r_s3_odd_lo;
        bot_hi = r_s3_col_same ? bot_lo : (r_s3_top_odd ? r_s3_even_hi : r_s3_odd_hi);
        // clamped row or column: the unused neighbour copies its partner
        sc     = r_s3_row_same ? sa : bot_lo;
        sd     = r_s3_row_same ? sb : bot_hi;
        omx    = ONE_W - {1'b0, r_s3_wx};
        top_sum = TOP_W'(sa) * $signed(TOP_W'(omx)) + TOP_W'(sb) * $signed(TOP_W'(r_s3_wx));
        bot_sum = TOP_W'(sc) * $signed(TOP_W'(omx)) + TOP_W'(sd) * $signed(TOP_W'(r_s3_wx));
    end

    logic                    r_s4_vld, r_s4_oob;
    logic signed [TOP_W-1:0] r_s4_top, r_s4_bot;
    logic [FRAC_BITS-1:0]    r_s4_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_oob <= r_s3_oob;
        r_s4_top <= top_sum;
        r_s4_bot <= bot_sum;
        r_s4_wy  <= r_s3_wy;
    end

    // ---------------- stage 5: vertical blend on quotient and remainder parts ----------------
    logic signed [SAMPLE_W-1:0] qt, qb;
    logic [FRAC_BITS-1:0]       rt, rb;
    logic [FRAC_BITS:0]         omy;
    logic signed [U_W-1:0]      u_sum;
    logic [V_W-1:0]             v_sum;

    always_comb begin
        qt    = r_s4_top[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        qb    = r_s4_bot[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        rt    = r_s4_top[FRAC_BITS-1:0];
        rb    = r_s4_bot[FRAC_BITS-1:0];
        omy   = ONE_W - {1'b0, r_s4_wy};
        u_sum = U_W'(qt) * $signed(U_W'(omy)) + U_W'(qb) * $signed(U_W'(r_s4_wy));
        v_sum = V_W'(rt) * V_W'(omy) + V_W'(rb) * V_W'(r_s4_wy);
    end

    logic                  r_s5_vld, r_s5_oob;
    logic signed [U_W-1:0] r_s5_u;
    logic [V_W-1:0]        r_s5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_oob <= r_s4_oob;
        r_s5_u   <= u_sum;
        r_s5_v   <= v_sum;
    end

    // ---------------- final: recombine and truncate toward zero ----------------
    logic [V_W-FRAC_BITS-1:0] q1;
    logic [FRAC_BITS-1:0]     r1, r2;
    logic signed [SUM_W-1:0]  fsum;
    logic signed [Q_W-1:0]    q2, q2_fix;
    logic [SAMPLE_W-1:0]      pix;

    always_comb begin
        q1     = r_s5_v[V_W-1:FRAC_BITS];
        r1     = r_s5_v[FRAC_BITS-1:0];
        fsum   = SUM_W'(r_s5_u) + $signed(SUM_W'(q1));
        q2     = fsum[SUM_W-1:FRAC_BITS];
        r2     = fsum[FRAC_BITS-1:0];
        // floor to truncation for negative values with a nonzero remainder
        q2_fix = (q2[Q_W-1] && (r1 != '0 || r2 != '0)) ? q2 + Q_W'(1) : q2;
        pix    = q2_fix[SAMPLE_W-1:0];
    end

    logic    r_out_vld;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.pixel_value <= r_s5_oob ? '0 : pix;
        r_out.status      <= r_s5_oob ? STATUS_RANGE : STATUS_OK;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire
